@@ rtl/hdlc_byte_unstuff_deframer_defines.svh @@
// Assertion macros for the HDLC byte unstuffing deframer.
`ifndef HDLC_BYTE_UNSTUFF_DEFRAMER_DEFINES_SVH
`define HDLC_BYTE_UNSTUFF_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that an implication property holds on every clock edge outside reset.
`define HDLC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hdlc deframer assertion failed");
// Check that a condition never holds outside reset.
`define HDLC_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("hdlc deframer forbidden condition seen");
`else
`define HDLC_ASSERT(label, clk, rst, prop)
`define HDLC_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

@@ rtl/hdlc_pkg.sv @@
// Package with codes, widths and constants of the HDLC byte unstuffing deframer.
`timescale 1ns / 1ps
`default_nettype none
package hdlc_pkg;

  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int KIND_W     = 2;
  localparam int OUT_DATA_W = BYTE_W + COUNT_W;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Input operation codes carried on the input tuser
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Register indexes, taken from paddr[2]
  localparam logic REG_FLAG   = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  // Bytes that follow an escape prefix
  localparam logic [BYTE_W-1:0] ESC_FLAG_CODE   = 8'h5E;
  localparam logic [BYTE_W-1:0] ESC_ESCAPE_CODE = 8'h5D;

  localparam logic [BYTE_W-1:0]  FLAG_RESET   = 8'h7E;
  localparam logic [BYTE_W-1:0]  ESCAPE_RESET = 8'h7D;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA       = 2'd0,
    KIND_DONE       = 2'd1,
    KIND_BAD_ESCAPE = 2'd2,
    KIND_TIMEOUT    = 2'd3
  } kind_t;

endpackage
`default_nettype wire

@@ rtl/hdlc_byte_unstuff_deframer.sv @@
// Top level of the HDLC byte unstuffing deframer: framing state, result register, APB registers.
`timescale 1ns / 1ps
`default_nettype none
`include "hdlc_byte_unstuff_deframer_defines.svh"

// Strips async HDLC/PPP framing from a received byte stream. Bytes are ignored until the
// flag byte opens a frame; inside it the escape byte arms an escape, after which 0x5E
// gives the flag byte and 0x5D the escape byte, and anything else aborts the frame.
// An unescaped flag closes the frame; a timeout request aborts an open one. Each data
// byte comes out with kind 0 and the running count; the end of a frame comes out with
// its kind and the saturating count. One request is taken every cycle unless the output
// register is held full: the work is a compare and a 16-bit saturating increment between
// the state registers and a single output register, which a result leaves in the cycle
// after its request. A request is taken while that register is empty or is being emptied
// in the same cycle. The flag and escape values sit at APB byte addresses 0 and 4.
module hdlc_byte_unstuff_deframer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [hdlc_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                              s_axis_tuser,  // [0] operation
  // Result stream
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [hdlc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [7:0] payload_byte,
                                                                // [23:8] frame_length
  output      logic [hdlc_pkg::KIND_W-1:0]       m_axis_tuser,  // [1:0] kind
  // Configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hdlc_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [hdlc_pkg::APB_DATA_W-1:0]   pwdata,
  output      logic [hdlc_pkg::APB_DATA_W-1:0]   prdata,
  output      logic                              pready
);
  import hdlc_pkg::*;

  logic [BYTE_W-1:0]  flag_byte;
  logic [BYTE_W-1:0]  escape_byte;
  logic               in_frame;
  logic               escape_pending;
  logic [COUNT_W-1:0] byte_count;

  logic               in_frame_next;
  logic               escape_pending_next;
  logic [COUNT_W-1:0] byte_count_next;
  logic [COUNT_W-1:0] count_inc;

  logic               res_valid;
  kind_t              res_kind;
  logic [BYTE_W-1:0]  res_payload;
  logic [COUNT_W-1:0] res_length;

  logic               out_valid;
  kind_t              out_kind;
  logic [BYTE_W-1:0]  out_payload;
  logic [COUNT_W-1:0] out_length;

  logic               s_accept;
  logic               cfg_write;

  // Handshakes
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite && pready;

  // Register read back
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_FLAG:   prdata[BYTE_W-1:0] = flag_byte;
      REG_ESCAPE: prdata[BYTE_W-1:0] = escape_byte;
      default:    prdata = '0;
    endcase
  end

  // Saturating data count
  assign count_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;

  // Decode one request against the framing state
  always_comb begin
    res_valid           = 1'b0;
    res_kind            = KIND_DATA;
    res_payload         = '0;
    res_length          = byte_count;
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    byte_count_next     = byte_count;
    if (s_axis_tuser == OP_TIMEOUT) begin
      // Abort an open frame; nothing to do while idle
      if (in_frame) begin
        res_valid           = 1'b1;
        res_kind            = KIND_TIMEOUT;
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
        byte_count_next     = '0;
      end
    end else if (!in_frame) begin
      // Hunt for the opening flag
      if (s_axis_tdata == flag_byte) begin
        in_frame_next       = 1'b1;
        escape_pending_next = 1'b0;
        byte_count_next     = '0;
      end
    end else if (escape_pending) begin
      // Resolve the escaped byte
      escape_pending_next = 1'b0;
      if (s_axis_tdata == ESC_FLAG_CODE || s_axis_tdata == ESC_ESCAPE_CODE) begin
        res_valid       = 1'b1;
        res_kind        = KIND_DATA;
        res_payload     = (s_axis_tdata == ESC_FLAG_CODE) ? flag_byte : escape_byte;
        res_length      = count_inc;
        byte_count_next = count_inc;
      end else begin
        res_valid       = 1'b1;
        res_kind        = KIND_BAD_ESCAPE;
        in_frame_next   = 1'b0;
        byte_count_next = '0;
      end
    end else if (s_axis_tdata == escape_byte) begin
      escape_pending_next = 1'b1;
    end else if (s_axis_tdata == flag_byte) begin
      // Closing flag
      res_valid           = 1'b1;
      res_kind            = KIND_DONE;
      in_frame_next       = 1'b0;
      escape_pending_next = 1'b0;
      byte_count_next     = '0;
    end else begin
      res_valid       = 1'b1;
      res_kind        = KIND_DATA;
      res_payload     = s_axis_tdata;
      res_length      = count_inc;
      byte_count_next = count_inc;
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte      <= FLAG_RESET;
      escape_byte    <= ESCAPE_RESET;
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          REG_FLAG:   flag_byte   <= pwdata[BYTE_W-1:0];
          REG_ESCAPE: escape_byte <= pwdata[BYTE_W-1:0];
          default:    ;
        endcase
      end
      if (s_accept) begin
        in_frame       <= in_frame_next;
        escape_pending <= escape_pending_next;
        byte_count     <= byte_count_next;
        out_valid      <= res_valid;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (s_accept && res_valid) begin
      out_kind    <= res_kind;
      out_payload <= res_payload;
      out_length  <= res_length;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_length, out_payload};
  assign m_axis_tuser  = out_kind;

  // Checks
  `HDLC_ASSERT_NEVER(a_escape_only_in_frame, clk, rst, !in_frame && escape_pending)
  `HDLC_ASSERT_NEVER(a_data_counted, clk, rst,
    out_valid && out_kind == KIND_DATA && out_length == '0)
  `HDLC_ASSERT_NEVER(a_end_no_payload, clk, rst,
    out_valid && out_kind != KIND_DATA && out_payload != '0)
  `HDLC_ASSERT(a_close_reported, clk, rst,
    (!$past(rst) && $fell(in_frame)) |-> (out_valid && out_kind != KIND_DATA))

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the HDLC byte unstuffing deframer, driven over stream and APB ports.
`timescale 1ns / 1ps

module testbench;
  import hdlc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;

  // One result of the deframer as it leaves the result stream
  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  payload;
    logic [COUNT_W-1:0] length;
  } deframe_event_t;

  // Tracks the framing state and holds the results that accepted requests must produce
  class deframe_scoreboard;
    logic [BYTE_W-1:0]  flag_val;
    logic [BYTE_W-1:0]  escape_val;
    bit                 in_frame;
    bit                 esc_armed;
    logic [COUNT_W-1:0] byte_count;
    deframe_event_t     expected_q[$];
    int                 errors;

    function new();
      flag_val   = FLAG_RESET;
      escape_val = ESCAPE_RESET;
      in_frame   = 1'b0;
      esc_armed  = 1'b0;
      byte_count = '0;
      errors     = 0;
    endfunction

    function void set_register(logic idx, logic [BYTE_W-1:0] value);
      if (idx == REG_FLAG) flag_val = value;
      else escape_val = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_event(kind_t kind, logic [BYTE_W-1:0] payload, logic [COUNT_W-1:0] len);
      deframe_event_t ev;
      ev.kind    = kind;
      ev.payload = payload;
      ev.length  = len;
      expected_q = {expected_q, ev};
    endfunction

    // Count a recovered byte, saturating, and queue it
    function void push_data(logic [BYTE_W-1:0] value);
      if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
      push_event(KIND_DATA, value, byte_count);
    endfunction

    // Report the end of the frame and drop back to hunting for a flag
    function void close_frame(kind_t kind);
      push_event(kind, '0, byte_count);
      in_frame   = 1'b0;
      esc_armed  = 1'b0;
      byte_count = '0;
    endfunction

    function void note_request(logic op, logic [BYTE_W-1:0] b);
      if (op == OP_TIMEOUT) begin
        if (in_frame) close_frame(KIND_TIMEOUT);
      end else if (!in_frame) begin
        if (b == flag_val) begin
          in_frame   = 1'b1;
          esc_armed  = 1'b0;
          byte_count = '0;
        end
      end else if (esc_armed) begin
        // the escape mapping wins over delimiter handling
        esc_armed = 1'b0;
        if (b == ESC_FLAG_CODE) push_data(flag_val);
        else if (b == ESC_ESCAPE_CODE) push_data(escape_val);
        else close_frame(KIND_BAD_ESCAPE);
      end else if (b == escape_val) begin
        esc_armed = 1'b1;
      end else if (b == flag_val) begin
        close_frame(KIND_DONE);
      end else begin
        push_data(b);
      end
    endfunction

    function void check_result(kind_t kind, logic [BYTE_W-1:0] payload,
                               logic [COUNT_W-1:0] len);
      deframe_event_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d payload %0h frame_length %0d", kind, payload, len);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (payload !== want.payload) begin
        $error("payload_byte: expected %0h, got %0h", want.payload, payload);
        errors++;
      end
      if (len !== want.length) begin
        $error("frame_length: expected %0d, got %0d", want.length, len);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_BYTE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  deframe_scoreboard board = new();
  int gap_pct     = 0;
  int hold_cycles = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  hdlc_byte_unstuff_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check every result taken from the block
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(kind_t'(m_axis_tuser), m_axis_tdata[BYTE_W-1:0],
                         m_axis_tdata[OUT_DATA_W-1:BYTE_W]);
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if ($urandom_range(99) < gap_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Draw a random byte
  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Offer one request, with an optional gap before it, and hold until it is taken
  task automatic push_request(input logic op, input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(op, b);
    items_sent++;
  endtask

  // Stop offering and let every pending result drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [BYTE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DATA_W-BYTE_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(idx, value);
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic set_delimiters(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc);
    wait_idle();
    apb_write(REG_FLAG, flag);
    apb_write(REG_ESCAPE, esc);
  endtask

  task automatic push_escaped(input logic [BYTE_W-1:0] b);
    push_request(OP_BYTE, board.escape_val);
    push_request(OP_BYTE, b);
  endtask

  // One frame with random content: line noise, flag, data, then an end of some sort or none
  task automatic send_frame();
    int n;
    int pick;
    repeat ($urandom_range(0, 2)) push_request(OP_BYTE, rand_byte());
    if ($urandom_range(9) == 0) push_request(OP_TIMEOUT, rand_byte());
    push_request(OP_BYTE, board.flag_val);
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (n) begin
      pick = $urandom_range(9);
      if (pick == 0) push_escaped(ESC_FLAG_CODE);
      else if (pick == 1) push_escaped(ESC_ESCAPE_CODE);
      else push_request(OP_BYTE, rand_byte());
    end
    pick = $urandom_range(19);
    if (pick < 13) push_request(OP_BYTE, board.flag_val);
    else if (pick < 16) push_escaped(rand_byte());
    else if (pick < 18) push_request(OP_TIMEOUT, rand_byte());
    else if (pick == 18) begin
      push_request(OP_BYTE, board.escape_val);
      push_request(OP_TIMEOUT, rand_byte());
    end
    // otherwise leave the frame open for the next one to run into
  endtask

  task automatic send_frames(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_frame();
  endtask

  initial begin
    logic [BYTE_W-1:0] b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle traffic, escapes, every kind of frame end, default delimiters
    gap_pct = 25;
    push_request(OP_TIMEOUT, 8'hFF);
    push_request(OP_BYTE, 8'h00);
    push_request(OP_BYTE, 8'hFF);
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, 8'h00);
    push_request(OP_BYTE, 8'hFF);
    push_escaped(ESC_FLAG_CODE);
    push_escaped(ESC_ESCAPE_CODE);
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, 8'h41);
    push_escaped(FLAG_RESET);
    push_request(OP_BYTE, FLAG_RESET);
    push_escaped(8'h00);
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, 8'h5E);
    push_request(OP_TIMEOUT, 8'h00);
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, ESCAPE_RESET);
    push_request(OP_TIMEOUT, 8'hA5);

    // Extreme delimiter values
    set_delimiters(8'h00, 8'hFF);
    send_frames(300);
    gap_pct = 5;
    set_delimiters(8'hFF, 8'h00);
    send_frames(300);

    // Delimiters that collide with the escape codes
    gap_pct = 30;
    set_delimiters(ESC_FLAG_CODE, ESC_ESCAPE_CODE);
    send_frames(200);
    set_delimiters(ESC_ESCAPE_CODE, ESC_FLAG_CODE);
    send_frames(100);

    // Flag equal to escape: every such byte inside a frame arms an escape unless one is already armed
    b = rand_byte();
    set_delimiters(b, b);
    send_frames(150);

    // Back-pressure: stall the result side while data keeps coming
    set_delimiters(FLAG_RESET, ESCAPE_RESET);
    gap_pct = 0;
    hold_cycles = 300;
    push_request(OP_BYTE, FLAG_RESET);
    repeat (60) push_request(OP_BYTE, rand_byte());
    push_request(OP_BYTE, FLAG_RESET);
    gap_pct = 20;
    send_frames(250);

    // Random delimiters
    set_delimiters(rand_byte(), rand_byte());
    send_frames(300);

    // Final stretch with no idling on either side: one longer frame, then a short one closed by a timeout
    gap_pct = 0;
    set_delimiters(FLAG_RESET, ESCAPE_RESET);
    send_frames(100);
    push_request(OP_BYTE, FLAG_RESET);
    repeat (40) begin
      b = rand_byte();
      if (b == FLAG_RESET || b == ESCAPE_RESET) push_escaped(ESC_FLAG_CODE);
      else push_request(OP_BYTE, b);
    end
    push_request(OP_BYTE, FLAG_RESET);
    push_request(OP_BYTE, FLAG_RESET);
    repeat (3) push_request(OP_BYTE, rand_byte());
    push_request(OP_TIMEOUT, 8'h00);

    // Drain and report
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ hdlc_byte_unstuff_deframer.f @@
+incdir+rtl
rtl/hdlc_pkg.sv
rtl/hdlc_byte_unstuff_deframer.sv
test/testbench.sv
